[rtl/pcr_pkg.sv]
// Shared types, constants and helper functions for the palette colour resolver.
// Used by pcr_ctrl, pcr_datapath and palette_color_resolver; no dependencies.
package pcr_pkg;

  localparam int DEPTH_DEFAULT = 256;

  localparam int COLOR_W = 24;
  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int SQ_W    = 16;
  localparam int DIST_W  = 18;

  localparam logic [KIND_W-1:0] KIND_EXACT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NEAREST = 2'd2;

  localparam logic REG_SNAP_MODE     = 1'b0;
  localparam logic REG_PALETTE_LIMIT = 1'b1;

  localparam logic [BYTE_W-1:0] LIMIT_RESET = 8'hFF;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } pcr_state_t;

  typedef struct packed {
    logic start;
    logic scan_run;
    logic finish;
  } pcr_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } pcr_status_t;

  function automatic logic [SQ_W-1:0] diff_sq(input logic [BYTE_W-1:0] a,
                                              input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

endpackage

[rtl/pcr_ctrl.sv]
// Controller state machine of the palette colour resolver.
// Depends on pcr_pkg for the state, command and status types.
module pcr_ctrl
  import pcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  pcr_status_t status,
  output pcr_cmd_t    cmd
);

  pcr_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.start    = 1'b0;
    cmd.scan_run = 1'b0;
    cmd.finish   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (status.scan_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/pcr_datapath.sv]
// Datapath of the palette colour resolver: palette memory, scan pipeline,
// configuration registers and output register. Depends on pcr_pkg.
module pcr_datapath
  import pcr_pkg::*;
#(
  parameter int PALETTE_DEPTH = DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  pcr_cmd_t           cmd,
  output pcr_status_t        status,
  input  logic [COLOR_W-1:0] in_color,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [BYTE_W-1:0]  cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BYTE_W-1:0]  out_index,
  output logic [KIND_W-1:0]  out_kind,
  output logic [BYTE_W-1:0]  out_count
);

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam logic [BYTE_W:0] DEPTH_LIM = (BYTE_W + 1)'(PALETTE_DEPTH);

  logic [COLOR_W-1:0] mem [PALETTE_DEPTH];

  logic               snap_mode;
  logic [BYTE_W-1:0]  palette_limit;
  logic [BYTE_W-1:0]  used_count;

  logic [COLOR_W-1:0] target;
  logic [BYTE_W-1:0]  addr;
  logic               p1_valid;
  logic [BYTE_W-1:0]  p1_idx;
  logic [COLOR_W-1:0] rd_data;
  logic               p2_valid;
  logic [BYTE_W-1:0]  p2_idx;
  logic               p2_eq;
  logic [SQ_W-1:0]    sq_r, sq_g, sq_b;
  logic [DIST_W-1:0]  dist_sum;
  logic               found;
  logic [BYTE_W-1:0]  match_idx;
  logic [DIST_W-1:0]  best_d;
  logic [BYTE_W-1:0]  best_idx;
  logic               issue;
  logic [BYTE_W:0]    limit_eff;
  logic               full;
  logic               append;

  assign issue  = cmd.scan_run && (addr < used_count);
  assign dist_sum = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
  assign limit_eff = ({1'b0, palette_limit} < DEPTH_LIM) ? {1'b0, palette_limit} : DEPTH_LIM;
  assign full   = ({1'b0, used_count} >= limit_eff);
  assign append = !found && !snap_mode && !full;

  assign status.scan_done = cmd.scan_run && !issue && !p1_valid && !p2_valid;
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_mode     <= 1'b0;
      palette_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SNAP_MODE:     snap_mode     <= cfg_data[0];
        REG_PALETTE_LIMIT: palette_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[addr[AW-1:0]];
    end
    if (cmd.finish && append) begin
      mem[used_count[AW-1:0]] <= target;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      p1_valid <= issue;
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      target <= in_color;
      addr   <= '0;
    end else if (issue) begin
      addr <= addr + 1'b1;
    end
    p1_idx <= addr;
    p2_idx <= p1_idx;
    p2_eq  <= (rd_data == target);
    sq_r   <= diff_sq(rd_data[23:16], target[23:16]);
    sq_g   <= diff_sq(rd_data[15:8], target[15:8]);
    sq_b   <= diff_sq(rd_data[7:0], target[7:0]);
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      found     <= 1'b0;
      match_idx <= '0;
      best_d    <= '1;
      best_idx  <= '0;
    end else if (p2_valid) begin
      if (!found && p2_eq) begin
        found     <= 1'b1;
        match_idx <= p2_idx;
      end
      if (dist_sum < best_d) begin
        best_d   <= dist_sum;
        best_idx <= p2_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid <= 1'b1;
        if (append) begin
          used_count <= used_count + 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (found) begin
        out_index <= match_idx;
        out_kind  <= KIND_EXACT;
        out_count <= used_count;
      end else if (append) begin
        out_index <= used_count;
        out_kind  <= KIND_APPEND;
        out_count <= used_count + 1'b1;
      end else begin
        out_index <= best_idx;
        out_kind  <= KIND_NEAREST;
        out_count <= used_count;
      end
    end
  end

endmodule

[rtl/palette_color_resolver.sv]
// Palette colour resolver: maps a 24-bit RGB word onto a palette index.
// Takes one word at a time: s_tready is high only while idle, so a new word waits until
// the last result has been loaded into the output register. Each word is resolved by a
// one-entry-per-cycle scan of the entries in use through a three-stage distance pipeline.
// Reset (rst, synchronous): palette empty, snap mode off, limit 255; memory not cleared.
// Depends on pcr_pkg, pcr_ctrl and pcr_datapath.
module palette_color_resolver
  import pcr_pkg::*;
#(
  parameter int PALETTE_DEPTH = DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [COLOR_W-1:0]  s_tdata,   // target_color
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [15:0]         m_tdata,   // palette_index, entry_count
  output logic [KIND_W-1:0]   m_tuser,   // resolve_kind
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [BYTE_W-1:0]   cfg_data
);

  pcr_cmd_t          cmd;
  pcr_status_t       status;
  logic [BYTE_W-1:0] out_index;
  logic [BYTE_W-1:0] out_count;

  pcr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  pcr_datapath #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_color  (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_index (out_index),
    .out_kind  (m_tuser),
    .out_count (out_count)
  );

  assign m_tdata = {out_count, out_index};

endmodule
